// ----- hw/rtl/fsf_pkg.sv -----
package fsf_pkg;

  // seen table
  localparam int TABLE_DEPTH = 512;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // fnv-1a 32
  localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME    = 32'd16777619;
  // prime is 2^24 plus a small odd part
  localparam logic [31:0] FNV_PRIME_LO = FNV_PRIME - 32'h0100_0000;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [2:0] {
    KIND_FEED   = 3'd0,
    KIND_TITLE  = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_LOOKUP = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FEED_CAP  = 1'd0,
    REG_TITLE_CAP = 1'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    HOP_NONE   = 3'd0,
    HOP_FEED   = 3'd1,
    HOP_SEP    = 3'd2,
    HOP_TITLE  = 3'd3,
    HOP_FINISH = 3'd4
  } hop_t;

  typedef struct packed {
    hop_t       op;
    logic [7:0] data;
  } hash_cmd_t;

  // search token walking down the row of table cells
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [CNT_W-1:0] left;
    logic [31:0]      key;
  } probe_t;

  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return (x << 24) + (x * FNV_PRIME_LO);
  endfunction

endpackage

// ----- hw/rtl/fsf_hash.sv -----
module fsf_hash (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         feed_cap,
  input  logic [7:0]         title_cap,
  input  fsf_pkg::hash_cmd_t cmd,
  output logic               in_title,
  output logic [31:0]        final_hash
);

  logic [31:0] running_hash;
  logic [7:0]  feed_taken;
  logic [7:0]  title_taken;
  logic [31:0] sep_hash;

  assign sep_hash   = fsf_pkg::fnv_mix(running_hash, 8'd0);
  // separator goes in if the key never reached its title, zero maps to one
  assign final_hash = in_title ? ((running_hash == 32'd0) ? 32'd1 : running_hash)
                               : ((sep_hash == 32'd0) ? 32'd1 : sep_hash);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= fsf_pkg::FNV_BASIS;
      in_title     <= 1'b0;
      feed_taken   <= 8'd0;
      title_taken  <= 8'd0;
    end else begin
      case (cmd.op)
        fsf_pkg::HOP_FEED: begin
          if (!in_title && (feed_taken < feed_cap)) begin
            running_hash <= fsf_pkg::fnv_mix(running_hash, cmd.data);
            feed_taken   <= feed_taken + 8'd1;
          end
        end
        fsf_pkg::HOP_SEP: begin
          running_hash <= sep_hash;
          in_title     <= 1'b1;
        end
        fsf_pkg::HOP_TITLE: begin
          if (title_taken < title_cap) begin
            running_hash <= fsf_pkg::fnv_mix(running_hash, cmd.data);
            title_taken  <= title_taken + 8'd1;
          end
        end
        fsf_pkg::HOP_FINISH: begin
          running_hash <= fsf_pkg::FNV_BASIS;
          in_title     <= 1'b0;
          feed_taken   <= 8'd0;
          title_taken  <= 8'd0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/fsf_cell.sv -----
module fsf_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic [31:0]       entry_in,
  output logic [31:0]       entry_out,
  input  fsf_pkg::probe_t   probe_in,
  output fsf_pkg::probe_t   probe_out
);

  logic [31:0]               entry;
  logic                      pr_valid;
  logic                      pr_hit;
  logic [fsf_pkg::CNT_W-1:0] pr_left;
  logic [31:0]               pr_key;
  logic                      live;

  assign live      = (probe_in.left != '0);
  assign entry_out = entry;
  assign probe_out = '{valid: pr_valid, hit: pr_hit, left: pr_left, key: pr_key};

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else begin
      pr_valid <= probe_in.valid;
    end
  end

  // only cells still inside the fill count take part in the match
  always_ff @(posedge clk) begin
    pr_key  <= probe_in.key;
    pr_hit  <= probe_in.hit | (live && (probe_in.key == entry));
    pr_left <= live ? (probe_in.left - 1'b1) : probe_in.left;
  end

endmodule

// ----- hw/rtl/fsf_table.sv -----
module fsf_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            insert,
  input  logic            clear,
  input  logic            launch,
  input  logic [31:0]     key,
  output logic            room,
  output fsf_pkg::probe_t tail
);

  logic [fsf_pkg::CNT_W-1:0] entry_count;
  logic                      shift;
  fsf_pkg::probe_t           head;
  logic                      head_valid;
  logic [fsf_pkg::CNT_W-1:0] head_left;
  logic [31:0]               head_key;

  logic [31:0]     entry_link [fsf_pkg::TABLE_DEPTH+1];
  fsf_pkg::probe_t probe_link [fsf_pkg::TABLE_DEPTH+1];

  assign room  = (entry_count < fsf_pkg::CNT_W'(fsf_pkg::TABLE_DEPTH));
  assign shift = insert && room;

  // newest entry enters cell 0, older ones move one cell on
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (clear) begin
      entry_count <= '0;
    end else if (shift) begin
      entry_count <= entry_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else begin
      head_valid <= launch;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      head_left <= entry_count;
      head_key  <= key;
    end
  end

  assign head          = '{valid: head_valid, hit: 1'b0, left: head_left, key: head_key};
  assign entry_link[0] = key;
  assign probe_link[0] = head;

  for (genvar i = 0; i < fsf_pkg::TABLE_DEPTH; i++) begin : g_cell
    fsf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .entry_in  (entry_link[i]),
      .entry_out (entry_link[i+1]),
      .probe_in  (probe_link[i]),
      .probe_out (probe_link[i+1])
    );
  end

  assign tail = probe_link[fsf_pkg::TABLE_DEPTH];

endmodule

// ----- hw/rtl/fnv1a_seen_set_filter.sv -----
// fnv-1a seen-set filter
// s_* channel: one transaction per key item; s_tuser carries the item kind
//   (feed byte, title byte, end key and insert, end key and look up, clear)
//   and s_tdata the key byte. end-insert and end-lookup each give one result
//   transaction on m_*; the other kinds give none.
// cfg_* channel: writes feed_cap (index 0) or title_cap (index 1), always
//   ready; write only while the block is idle.
// sequencing: the first title byte of a key is split into two steps (separator,
//   then the byte), and no item is taken between them. end-insert loads its
//   result into the output register, valid the cycle after.
// end-lookup: the search token walks the row of TABLE_DEPTH table cells one
//   cell per cycle, then the result is registered and loaded into the output
//   register, and no item is taken meanwhile.
// reset: key restarts at the offset basis, table empty, caps 31 and 127.
// stall: one output register; while it holds an untaken result the block
//   takes no new item, and a finished lookup waits for it to drain.
module fnv1a_seen_set_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] data_byte
  input  logic [2:0]                    s_tuser,   // [2:0] kind
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [39:0]                   m_tdata,   // [31:0] key_hash, [32] found,
                                                   // [33] stored, [39:34] zero
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE       = 4'b0001,
    ST_TITLE_BYTE = 4'b0010,
    ST_LOOKUP     = 4'b0100,
    ST_RESULT     = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [7:0]         feed_cap;
  logic [7:0]         title_cap;
  logic               accept;
  logic               out_free;
  fsf_pkg::kind_t     kind;
  fsf_pkg::hash_cmd_t hcmd;
  logic               in_title;
  logic [31:0]        final_hash;
  logic               tbl_insert;
  logic               tbl_clear;
  logic               tbl_launch;
  logic               room;
  fsf_pkg::probe_t    tail;
  logic [7:0]         pend_byte;
  logic [31:0]        res_hash;
  logic               res_hit;
  logic               out_load;
  logic [31:0]        load_hash;
  logic               load_found;
  logic               load_stored;
  logic [31:0]        out_hash;
  logic               out_found;
  logic               out_stored;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign kind      = fsf_pkg::kind_t'(s_tuser);
  assign m_tdata   = {6'd0, out_stored, out_found, out_hash};

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      feed_cap  <= 8'd31;
      title_cap <= 8'd127;
    end else if (cfg_valid && cfg_ready) begin
      case (fsf_pkg::reg_idx_t'(cfg_index))
        fsf_pkg::REG_FEED_CAP:  feed_cap  <= cfg_data;
        fsf_pkg::REG_TITLE_CAP: title_cap <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // item sequencing
  always_comb begin
    state_next  = state;
    hcmd        = '{op: fsf_pkg::HOP_NONE, data: s_tdata};
    tbl_insert  = 1'b0;
    tbl_clear   = 1'b0;
    tbl_launch  = 1'b0;
    out_load    = 1'b0;
    load_hash   = final_hash;
    load_found  = 1'b0;
    load_stored = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            fsf_pkg::KIND_FEED: begin
              hcmd.op = fsf_pkg::HOP_FEED;
            end
            fsf_pkg::KIND_TITLE: begin
              if (in_title) begin
                hcmd.op = fsf_pkg::HOP_TITLE;
              end else begin
                // separator first, byte on the next cycle
                hcmd.op    = fsf_pkg::HOP_SEP;
                state_next = ST_TITLE_BYTE;
              end
            end
            fsf_pkg::KIND_INSERT: begin
              hcmd.op     = fsf_pkg::HOP_FINISH;
              tbl_insert  = 1'b1;
              out_load    = 1'b1;
              load_stored = room;
            end
            fsf_pkg::KIND_LOOKUP: begin
              hcmd.op    = fsf_pkg::HOP_FINISH;
              tbl_launch = 1'b1;
              state_next = ST_LOOKUP;
            end
            fsf_pkg::KIND_CLEAR: begin
              tbl_clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_TITLE_BYTE: begin
        hcmd       = '{op: fsf_pkg::HOP_TITLE, data: pend_byte};
        state_next = ST_IDLE;
      end
      ST_LOOKUP: begin
        if (tail.valid) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_hash  = res_hash;
          load_found = res_hit;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_byte <= s_tdata;
    end
    if (tail.valid) begin
      res_hash <= tail.key;
      res_hit  <= tail.hit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hash   <= load_hash;
      out_found  <= load_found;
      out_stored <= load_stored;
    end
  end

  fsf_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .feed_cap   (feed_cap),
    .title_cap  (title_cap),
    .cmd        (hcmd),
    .in_title   (in_title),
    .final_hash (final_hash)
  );

  fsf_table u_table (
    .clk    (clk),
    .rst    (rst),
    .insert (tbl_insert),
    .clear  (tbl_clear),
    .launch (tbl_launch),
    .key    (final_hash),
    .room   (room),
    .tail   (tail)
  );

endmodule

// ----- tb/sv/fnv1a_seen_set_filter_tb.sv -----
`timescale 1ns / 100ps

module fnv1a_seen_set_filter_tb;

  // run shape
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int PHASE_ITEMS   = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTS    = 100;
  // kinds past the defined ones, the block ignores them
  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } key_item_t;

  typedef struct packed {
    logic [31:0] key_hash;
    logic        found;
    logic        stored;
  } verdict_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = '0;   // [7:0] data_byte
  logic [2:0]                    s_tuser = '0;   // [2:0] kind
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [39:0]                   m_tdata;        // [31:0] key_hash, [32] found,
                                                 // [33] stored, [39:34] zero
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fsf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                    cfg_data = '0;

  fnv1a_seen_set_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // items waiting to be driven, and results the key predictor has worked out
  key_item_t key_items[$];
  verdict_t  verdicts_due[$];
  int        items_queued = 0;
  int        mismatches = 0;

  // predictor state, a copy of the block's own
  logic [31:0] p_hash;
  bit          p_in_title;
  int          p_feed_n;
  int          p_title_n;
  logic [31:0] p_seen [fsf_pkg::TABLE_DEPTH];
  int          p_count;
  int          p_feed_cap;
  int          p_title_cap;

  // what the run went through
  int n_inserts = 0;
  int n_dropped = 0;
  int n_lookups = 0;
  int n_hits = 0;
  int n_hash_one = 0;

  // receiver hold-off request, raised once by the stimulus
  logic hold_req = 1'b0;

  // forward half of the search for a key that hashes to zero
  logic [31:0] fw_hash [0:65535];
  logic [15:0] fw_pair [0:65535];
  bit          fw_ok [0:65535];

  function automatic logic [31:0] fnv_byte(input logic [31:0] h, input logic [7:0] b);
    return (h ^ {24'd0, b}) * fsf_pkg::FNV_PRIME;
  endfunction

  // bytes of a recurring key, fixed by its id so that it can be sent again
  function automatic logic [7:0] pool_byte(input int id, input int seg, input int i);
    return 8'((id * 73 + seg * 151 + i * 29 + 5) & 255);
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_PRINTS)
      $display("mismatch: %s", what);
    mismatches++;
  endtask

  // separator between feed and title, hashed once per key
  task automatic open_title();
    if (!p_in_title) begin
      p_hash = fnv_byte(p_hash, 8'd0);
      p_in_title = 1'b1;
    end
  endtask

  task automatic predict_key_item(input logic [2:0] kind, input logic [7:0] b);
    verdict_t v;
    int       i;
    case (kind)
      fsf_pkg::KIND_FEED: begin
        if (!p_in_title && p_feed_n < p_feed_cap) begin
          p_hash = fnv_byte(p_hash, b);
          p_feed_n++;
        end
      end
      fsf_pkg::KIND_TITLE: begin
        open_title();
        if (p_title_n < p_title_cap) begin
          p_hash = fnv_byte(p_hash, b);
          p_title_n++;
        end
      end
      fsf_pkg::KIND_INSERT, fsf_pkg::KIND_LOOKUP: begin
        open_title();
        v.key_hash = (p_hash == 32'd0) ? 32'd1 : p_hash;
        v.found = 1'b0;
        v.stored = 1'b0;
        p_hash = fsf_pkg::FNV_BASIS;
        p_in_title = 1'b0;
        p_feed_n = 0;
        p_title_n = 0;
        if (v.key_hash == 32'd1)
          n_hash_one++;
        if (kind == fsf_pkg::KIND_INSERT) begin
          n_inserts++;
          if (p_count < fsf_pkg::TABLE_DEPTH) begin
            p_seen[p_count] = v.key_hash;
            p_count++;
            v.stored = 1'b1;
          end else begin
            n_dropped++;
          end
        end else begin
          n_lookups++;
          for (i = 0; i < p_count; i++)
            if (p_seen[i] == v.key_hash)
              v.found = 1'b1;
          if (v.found)
            n_hits++;
        end
        verdicts_due.push_back(v);
      end
      fsf_pkg::KIND_CLEAR: p_count = 0;
      default: ;
    endcase
  endtask

  // driver: bursts of random length, random gaps between them
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_items
    key_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0 || key_items.size() == 0) begin
        s_tvalid <= 1'b0;
        if (gap_left != 0)
          gap_left <= gap_left - 1;
      end else begin
        it = key_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= it.data;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: modes of random length (always ready, mostly ready, mostly
  // stalled), plus one long hold-off so the output fills and input backs up
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   mode = 0;
  int   mode_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      mode_left <= 0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      if (mode_left == 0) begin
        mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: check each result transaction, then feed the predictor with
  // accepted register writes and input transactions
  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst) begin
      p_hash = fsf_pkg::FNV_BASIS;
      p_in_title = 1'b0;
      p_feed_n = 0;
      p_title_n = 0;
      p_count = 0;
      p_feed_cap = 31;
      p_title_cap = 127;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch($sformatf("result %h with no result expected", m_tdata));
        end else begin
          want = verdicts_due.pop_front();
          if (m_tdata[31:0] !== want.key_hash)
            flag_mismatch($sformatf("key_hash %h, expected %h", m_tdata[31:0], want.key_hash));
          if (m_tdata[32] !== want.found)
            flag_mismatch($sformatf("found %b, expected %b for hash %h",
                                    m_tdata[32], want.found, want.key_hash));
          if (m_tdata[33] !== want.stored)
            flag_mismatch($sformatf("stored %b, expected %b for hash %h",
                                    m_tdata[33], want.stored, want.key_hash));
          if (m_tdata[39:34] !== 6'd0)
            flag_mismatch($sformatf("pad bits %b not zero", m_tdata[39:34]));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fsf_pkg::REG_FEED_CAP:  p_feed_cap = int'(cfg_data);
          fsf_pkg::REG_TITLE_CAP: p_title_cap = int'(cfg_data);
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        predict_key_item(s_tuser, s_tdata);
    end
  end

  // watchdog
  int cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, verdicts_due.size());
      $display("fnv1a_seen_set_filter test failed");
      $finish;
    end
  end

  task automatic send(input logic [2:0] kind, input logic [7:0] b);
    key_items.push_back({kind, b});
    items_queued++;
  endtask

  // id < 0 gives a key of fresh random bytes, else a recurring key
  task automatic push_key(input int nf, input int nt, input int id, input logic [2:0] end_kind);
    int i;
    for (i = 0; i < nf; i++)
      send(fsf_pkg::KIND_FEED, (id < 0) ? 8'($urandom_range(0, 255)) : pool_byte(id, 0, i));
    for (i = 0; i < nt; i++) begin
      send(fsf_pkg::KIND_TITLE, (id < 0) ? 8'($urandom_range(0, 255)) : pool_byte(id, 1, i));
      // stray feed byte inside the title, to be ignored
      if (id < 0 && $urandom_range(0, 15) == 0)
        send(fsf_pkg::KIND_FEED, 8'($urandom_range(0, 255)));
    end
    send(end_kind, 8'($urandom_range(0, 255)));
  endtask

  // mostly whole keys, recurring or with random content, some noise and unfinished keys
  task automatic random_phase(input int target);
    int start;
    int r;
    int id;
    int nf;
    int nt;
    int i;
    logic [2:0] end_kind;
    start = items_queued;
    while (items_queued - start < target) begin
      r = $urandom_range(0, 99);
      end_kind = ($urandom_range(0, 99) < 45) ? fsf_pkg::KIND_LOOKUP : fsf_pkg::KIND_INSERT;
      if (r < 3) begin
        send(fsf_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)));
      end else if (r < 6) begin
        key_items.push_back({KIND_UNUSED_FIRST + 3'($urandom_range(0, 2)),
                             8'($urandom_range(0, 255))});
      end else if (r < 10) begin
        // unfinished key, runs on into the next one
        nf = $urandom_range(0, 4);
        for (i = 0; i < nf; i++)
          send(fsf_pkg::KIND_FEED, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1))
          send(fsf_pkg::KIND_TITLE, 8'($urandom_range(0, 255)));
      end else if (r < 55) begin
        id = $urandom_range(0, 11);
        nf = id % 5 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        nt = (id * 3) % 7 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        push_key(nf, nt, id, end_kind);
      end else begin
        nf = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 45) : $urandom_range(0, 6);
        nt = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 8);
        push_key(nf, nt, -1, end_kind);
      end
    end
  endtask

  // sender pauses until every result is back and the block is quiet
  task automatic wait_drained();
    do @(negedge clk);
    while (key_items.size() != 0 || s_tvalid || verdicts_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cap(input fsf_pkg::reg_idx_t idx, input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_caps(input logic [7:0] fcap, input logic [7:0] tcap);
    wait_drained();
    if ($urandom_range(0, 1)) begin
      write_cap(fsf_pkg::REG_FEED_CAP, fcap);
      write_cap(fsf_pkg::REG_TITLE_CAP, tcap);
    end else begin
      write_cap(fsf_pkg::REG_TITLE_CAP, tcap);
      write_cap(fsf_pkg::REG_FEED_CAP, fcap);
    end
    @(negedge clk);
  endtask

  // meet in the middle: two feed bytes forward from the basis, three title
  // bytes backward from a final hash of zero, matched across the separator
  task automatic find_zero_key(output bit ok, output logic [39:0] bytes);
    logic [31:0] inv;
    logic [31:0] h;
    logic [31:0] hb1;
    logic [31:0] hf;
    int a;
    int b;
    int c;
    ok = 1'b0;
    bytes = '0;
    inv = fsf_pkg::FNV_PRIME;
    repeat (5) inv = inv * (32'd2 - fsf_pkg::FNV_PRIME * inv);
    for (a = 0; a < 256; a++)
      for (b = 0; b < 256; b++) begin
        h = fnv_byte(fnv_byte(fsf_pkg::FNV_BASIS, a[7:0]), b[7:0]);
        fw_hash[h[31:16]] = h;
        fw_pair[h[31:16]] = {a[7:0], b[7:0]};
        fw_ok[h[31:16]] = 1'b1;
      end
    for (c = 0; c < 256 && !ok; c++)
      for (b = 0; b < 256 && !ok; b++) begin
        hb1 = ({24'd0, c[7:0]} * inv) ^ {24'd0, b[7:0]};
        for (a = 0; a < 8 && !ok; a++) begin
          hf = ((hb1 * inv) ^ {24'd0, a[7:0]}) * inv;
          if (fw_ok[hf[31:16]] && fw_hash[hf[31:16]] == hf) begin
            ok = 1'b1;
            bytes = {fw_pair[hf[31:16]], a[7:0], b[7:0], c[7:0]};
          end
        end
      end
  endtask

  initial begin
    bit          zero_ok;
    logic [39:0] zero_key;
    int          i;
    find_zero_key(zero_ok, zero_key);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at reset caps
    send(fsf_pkg::KIND_INSERT, 8'h00);   // empty key, separator only
    send(fsf_pkg::KIND_LOOKUP, 8'hff);   // same key, now a hit
    send(fsf_pkg::KIND_FEED, 8'h00);
    send(fsf_pkg::KIND_FEED, 8'hff);
    send(fsf_pkg::KIND_TITLE, 8'h00);
    send(fsf_pkg::KIND_TITLE, 8'hff);
    send(fsf_pkg::KIND_INSERT, 8'h00);
    key_items.push_back({KIND_UNUSED_FIRST, 8'hff});
    send(fsf_pkg::KIND_FEED, 8'h00);
    send(fsf_pkg::KIND_FEED, 8'hff);
    key_items.push_back({KIND_UNUSED_FIRST + 3'd1, 8'h00});
    send(fsf_pkg::KIND_TITLE, 8'h00);
    send(fsf_pkg::KIND_TITLE, 8'hff);
    send(fsf_pkg::KIND_LOOKUP, 8'h00);
    // title with no feed, then a feed byte that must be ignored
    send(fsf_pkg::KIND_TITLE, 8'h5a);
    send(fsf_pkg::KIND_FEED, 8'h33);
    key_items.push_back({KIND_UNUSED_FIRST + 3'd2, 8'h80});
    send(fsf_pkg::KIND_LOOKUP, 8'h00);
    // clear in the middle of a key keeps the key
    send(fsf_pkg::KIND_FEED, 8'h11);
    send(fsf_pkg::KIND_CLEAR, 8'h00);
    send(fsf_pkg::KIND_TITLE, 8'h22);
    send(fsf_pkg::KIND_INSERT, 8'h00);
    // key whose hash comes out as zero, reported as one
    if (zero_ok) begin
      send(fsf_pkg::KIND_FEED, zero_key[39:32]);
      send(fsf_pkg::KIND_FEED, zero_key[31:24]);
      send(fsf_pkg::KIND_TITLE, zero_key[23:16]);
      send(fsf_pkg::KIND_TITLE, zero_key[15:8]);
      send(fsf_pkg::KIND_TITLE, zero_key[7:0]);
      send(fsf_pkg::KIND_INSERT, 8'h00);
    end

    // reset caps, with the long receiver hold-off while items keep coming
    wait_drained();
    random_phase(PHASE_ITEMS);
    hold_req <= 1'b1;

    set_caps(8'd1, 8'd1);
    random_phase(PHASE_ITEMS);

    // widest caps, one key longer than both
    set_caps(8'd255, 8'd255);
    push_key(257, 256, -1, fsf_pkg::KIND_INSERT);
    random_phase(PHASE_ITEMS / 2);

    set_caps(8'd0, 8'd3);
    random_phase(PHASE_ITEMS);

    set_caps(8'd3, 8'd0);
    random_phase(PHASE_ITEMS);

    set_caps(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    random_phase(PHASE_ITEMS);

    // fill the table past full, then look up and clear
    wait_drained();
    send(fsf_pkg::KIND_CLEAR, 8'h00);
    for (i = 0; i < fsf_pkg::TABLE_DEPTH + 2; i++) begin
      if ($urandom_range(0, 7) == 0)
        send(fsf_pkg::KIND_FEED, 8'($urandom_range(0, 255)));
      send(fsf_pkg::KIND_INSERT, 8'($urandom_range(0, 255)));
    end
    send(fsf_pkg::KIND_INSERT, 8'h00);
    send(fsf_pkg::KIND_LOOKUP, 8'h00);
    push_key(2, 2, -1, fsf_pkg::KIND_LOOKUP);
    send(fsf_pkg::KIND_CLEAR, 8'h00);
    send(fsf_pkg::KIND_LOOKUP, 8'h00);
    send(fsf_pkg::KIND_INSERT, 8'h00);

    wait_drained();
    repeat (fsf_pkg::TABLE_DEPTH + 16) @(negedge clk);

    $display("covered %0d inserts (%0d dropped on a full table), %0d lookups (%0d hits)",
             n_inserts, n_dropped, n_lookups, n_hits);
    $display("six cap settings incl. 0, 1 and 255; %0d keys hashing to zero; %0d mismatches",
             n_hash_one, mismatches);
    if (mismatches == 0) begin
      $display("fnv1a_seen_set_filter test passed");
    end else begin
      $display("fnv1a_seen_set_filter test failed");
    end
    $finish;
  end

endmodule
